FILE: rtl/dfa_pkg.sv
// Shared types, constants and the rounding multiply for the scaled Dawson pipeline.
// No dependencies; dfa_div, dfa_horner, dfa_exp and the top level import this package.
`timescale 1ns / 1ps
`default_nettype none

package dfa_pkg;

  typedef logic [7:0][33:0] coef_tbl_t;

  localparam int unsigned DIV_STAGES    = 15;
  localparam int unsigned HORNER_STAGES = 7;
  localparam int unsigned EXP_STAGES    = 12;

  localparam logic [31:0] ONE31    = 32'h8000_0000;
  localparam logic [31:0] SCALE_K  = 32'd1211587905;
  localparam logic [31:0] Q_305    = 32'd3274912563;
  localparam logic [31:0] Q_0092   = 32'd98784248;
  localparam logic [31:0] Q_00121  = 32'd12992276;
  localparam logic [31:0] Q_02253  = 32'd241914033;
  localparam logic [22:0] MAX_POS  = 23'h7F_FFFF;

  // Series P(y) coefficients, round(2^30/n), highest order first.
  localparam coef_tbl_t SER_COEF = {
    34'd14203, 34'd114716, 34'd813441, 34'd4971027,
    34'd25565282, 34'd107374182, 34'd357913941, 34'd1073741824
  };

  // Asymptotic S(w) coefficients in Q24, highest order first.
  localparam coef_tbl_t ASYM_COEF = {
    34'd135135 << 16, 34'd10395 << 17, 34'd945 << 18, 34'd105 << 19,
    34'd15 << 20, 34'd3 << 21, 34'd1 << 22, 34'd1 << 23
  };

  // Unsigned product rounded half up and shifted right by sh.
  function automatic logic [65:0] mul_rnd(input logic [33:0] a, input logic [31:0] b,
                                          input int unsigned sh);
    logic [65:0] p;
    p = 66'(a) * 66'(b) + (66'(1) << (sh - 1));
    return p >> sh;
  endfunction

endpackage

`default_nettype wire

FILE: rtl/dfa_dly.sv
// Fixed-length register delay line used to align data between pipeline branches.
// Depends on nothing.
`timescale 1ns / 1ps
`default_nettype none

module dfa_dly #(
  parameter int unsigned W = 1,
  parameter int unsigned N = 1
) (
  input  wire logic         clk,
  input  wire logic [W-1:0] d_i,
  output logic      [W-1:0] q_o
);

  logic [W-1:0] sr_r [N];

  always_ff @(posedge clk) begin
    sr_r[0] <= d_i;
    for (int i = 1; i < N; i++) begin
      sr_r[i] <= sr_r[i-1];
    end
  end

  assign q_o = sr_r[N-1];

endmodule

`default_nettype wire

FILE: rtl/dfa_div.sv
// Pipelined restoring divider, two quotient bits per stage, rounded reciprocal of |x|.
// Depends on dfa_pkg.
`timescale 1ns / 1ps
`default_nettype none

module dfa_div import dfa_pkg::*; (
  input  wire logic        clk,
  input  wire logic [23:0] dvs_i,
  input  wire logic [24:0] num_hi_i,
  input  wire logic [29:0] num_lo_i,
  output logic      [29:0] quo_o
);

  logic [24:0] rem_r [DIV_STAGES];
  logic [29:0] quo_r [DIV_STAGES];
  logic [29:0] lo_r  [DIV_STAGES];
  logic [23:0] dvs_r [DIV_STAGES];

  for (genvar j = 0; j < DIV_STAGES; j++) begin : g_st
    logic [24:0] rem_in;
    logic [29:0] quo_in;
    logic [29:0] lo_in;
    logic [23:0] dvs_in;
    logic [24:0] rem_nxt;
    logic [29:0] quo_nxt;
    logic [29:0] lo_nxt;

    if (j == 0) begin : g_first
      assign rem_in = num_hi_i;
      assign quo_in = '0;
      assign lo_in  = num_lo_i;
      assign dvs_in = dvs_i;
    end else begin : g_next
      assign rem_in = rem_r[j-1];
      assign quo_in = quo_r[j-1];
      assign lo_in  = lo_r[j-1];
      assign dvs_in = dvs_r[j-1];
    end

    always_comb begin
      logic [25:0] t;
      rem_nxt = rem_in;
      quo_nxt = quo_in;
      lo_nxt  = lo_in;
      for (int b = 0; b < 2; b++) begin
        t      = {rem_nxt, lo_nxt[29]};
        lo_nxt = {lo_nxt[28:0], 1'b0};
        if (t >= {2'b00, dvs_in}) begin
          t       = t - {2'b00, dvs_in};
          quo_nxt = {quo_nxt[28:0], 1'b1};
        end else begin
          quo_nxt = {quo_nxt[28:0], 1'b0};
        end
        rem_nxt = t[24:0];
      end
    end

    always_ff @(posedge clk) begin
      rem_r[j] <= rem_nxt;
      quo_r[j] <= quo_nxt;
      lo_r[j]  <= lo_nxt;
      dvs_r[j] <= dvs_in;
    end
  end

  assign quo_o = quo_r[DIV_STAGES-1];

endmodule

`default_nettype wire

FILE: rtl/dfa_horner.sv
// Pipelined Horner evaluation of a degree-7 polynomial, one multiply-add per stage.
// Depends on dfa_pkg for the coefficient table type and the rounding multiply.
`timescale 1ns / 1ps
`default_nettype none

module dfa_horner import dfa_pkg::*; (
  input  wire logic        clk,
  input  wire logic [31:0] mul_i,
  input  wire coef_tbl_t   coef_i,
  output logic      [33:0] res_o
);

  logic [33:0] p_r [HORNER_STAGES];
  logic [31:0] m_r [HORNER_STAGES-1];

  for (genvar k = 0; k < HORNER_STAGES; k++) begin : g_st
    logic [33:0] p_in;
    logic [31:0] m_in;
    logic [33:0] p_nxt;

    if (k == 0) begin : g_first
      assign p_in = coef_i[HORNER_STAGES];
      assign m_in = mul_i;
    end else begin : g_next
      assign p_in = p_r[k-1];
      assign m_in = m_r[k-1];
    end

    assign p_nxt = 34'(mul_rnd(p_in, m_in, 30)) + coef_i[HORNER_STAGES-1-k];

    always_ff @(posedge clk) begin
      p_r[k] <= p_nxt;
    end

    if (k < HORNER_STAGES - 1) begin : g_carry
      always_ff @(posedge clk) begin
        m_r[k] <= m_in;
      end
    end
  end

  assign res_o = p_r[HORNER_STAGES-1];

endmodule

`default_nettype wire

FILE: rtl/dfa_exp.sv
// Pipelined exp(-y): fourth-order Taylor on y/256 followed by eight squarings.
// Depends on dfa_pkg for the rounding multiply and Q31 one.
`timescale 1ns / 1ps
`default_nettype none

module dfa_exp import dfa_pkg::*; (
  input  wire logic        clk,
  input  wire logic [31:0] y_i,
  output logic      [31:0] e_o
);

  logic [25:0] u_c;
  logic [57:0] p3;
  logic [25:0] u_r [3];
  logic [24:0] u3_r;
  logic [31:0] t_r [EXP_STAGES];

  // u is y/256 in Q31; u/3 by reciprocal multiply, exact for u below 2^32.
  assign u_c = 26'((33'(y_i) + 33'd64) >> 7);
  assign p3  = 58'(u_c) * 58'(32'hAAAA_AAAB);

  always_ff @(posedge clk) begin
    u_r[0] <= u_c;
    u3_r   <= p3[57:33];
    t_r[0] <= ONE31 - 32'(u_c >> 2);
    u_r[1] <= u_r[0];
    t_r[1] <= ONE31 - 32'(mul_rnd(34'(u3_r), t_r[0], 31));
    u_r[2] <= u_r[1];
    t_r[2] <= ONE31 - 32'(mul_rnd(34'(u_r[1] >> 1), t_r[1], 31));
    t_r[3] <= ONE31 - 32'(mul_rnd(34'(u_r[2]), t_r[2], 31));
    for (int k = 4; k < EXP_STAGES; k++) begin
      t_r[k] <= 32'(mul_rnd(34'(t_r[k-1]), t_r[k-1], 31));
    end
  end

  assign e_o = t_r[EXP_STAGES-1];

endmodule

`default_nettype wire

FILE: rtl/scaled_dawson_function_approx_top.sv
// Top level of the scaled Dawson function pipeline.
// Depends on dfa_pkg, dfa_dly, dfa_div, dfa_horner and dfa_exp.
`timescale 1ns / 1ps
`default_nettype none

// This block computes 2/sqrt(pi) times the Dawson function of a signed argument with
// INPUT_FRACTION_BITS fraction bits and returns a saturated Q1.22 result. It takes one
// argument in every clock cycle: a transfer happens whenever start is high while busy is
// low, and busy is high only during reset and until its register is cleared after reset
// is released. Each result is flagged by a one-cycle out_valid strobe, in the order the
// arguments came in; the receiver cannot stall the pipeline, so results must be taken
// when they appear. The longest branch is the asymptotic one, which runs a 15-stage
// reciprocal divider (two quotient bits per stage) followed by a squaring, a 7-stage Horner
// pipeline and two scaling multiplies. The series and quadratic branches run alongside on
// every argument and are delayed to match, so all three answers are ready together and the
// branch chosen from |x| is selected before final scaling.

module scaled_dawson_function_approx_top import dfa_pkg::*; #(
  parameter int unsigned INPUT_FRACTION_BITS = 16
) (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               start,
  output logic                    busy,
  input  wire logic signed [23:0] in_x_value,
  output logic                    out_valid,
  output logic signed      [23:0] out_result_value
);

  localparam int unsigned SH  = 30 - INPUT_FRACTION_BITS;
  localparam int unsigned LAT = 28;

  typedef enum logic [1:0] {BR_SER, BR_QUAD, BR_ASYM} br_t;

  // Control: busy and the valid bits that travel alongside the data.
  logic            busy_r;
  logic [LAT-1:0]  vld_r;
  logic            accept;

  assign accept = start && !busy_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b1;
      vld_r  <= '0;
    end else begin
      busy_r <= 1'b0;
      vld_r  <= {vld_r[LAT-2:0], accept};
    end
  end

  // Stage 0: capture the argument.
  logic [23:0] raw_r;

  always_ff @(posedge clk) begin
    raw_r <= in_x_value;
  end

  // Stage 1: magnitude, sign, branch choice and the Q30 argument.
  logic [23:0] a_nxt;
  logic        ser_c;
  logic        asy_c;
  br_t         br_nxt;
  logic [23:0] a_r;
  logic        neg_r;
  br_t         br_r;
  logic [31:0] x30_r;

  assign a_nxt = raw_r[23] ? (~raw_r + 24'd1) : raw_r;
  // The bounds 1.5 and 2.6 are compared exactly on the raw magnitude.
  assign ser_c = (26'(a_nxt) << 1) <= (26'd3 << INPUT_FRACTION_BITS);
  assign asy_c = (29'(a_nxt) * 29'd5) >= (29'd13 << INPUT_FRACTION_BITS);
  assign br_nxt = ser_c ? BR_SER : (asy_c ? BR_ASYM : BR_QUAD);

  always_ff @(posedge clk) begin
    a_r   <= a_nxt;
    neg_r <= raw_r[23];
    br_r  <= br_nxt;
    x30_r <= 32'(a_nxt) << SH;
  end

  // Series branch: x * exp(-x^2) * P(x^2).
  logic [31:0] y_r;
  logic [33:0] p_h;
  logic [33:0] p_d;
  logic [31:0] e_x;
  logic [31:0] x30_d;
  logic [31:0] xe_r;
  logic [31:0] sv_r;
  logic [31:0] sv_d;

  always_ff @(posedge clk) begin
    y_r <= 32'(mul_rnd(34'(x30_r), x30_r, 30));
  end

  dfa_horner u_ser_poly (.clk(clk), .mul_i(y_r), .coef_i(SER_COEF), .res_o(p_h));
  dfa_exp    u_exp      (.clk(clk), .y_i(y_r), .e_o(e_x));
  dfa_dly #(.W(34), .N(6))  u_p_dly  (.clk(clk), .d_i(p_h), .q_o(p_d));
  dfa_dly #(.W(32), .N(13)) u_x_dly  (.clk(clk), .d_i(x30_r), .q_o(x30_d));

  always_ff @(posedge clk) begin
    xe_r <= 32'(mul_rnd(34'(x30_d), e_x, 31));
    sv_r <= 32'(mul_rnd(p_d, xe_r, 30));
  end

  dfa_dly #(.W(32), .N(9)) u_sv_dly (.clk(clk), .d_i(sv_r), .q_o(sv_d));

  // Quadratic branch: 0.092*(x-3.05)^2 - 0.0121*x + 0.2253.
  logic [31:0] d_c;
  logic [31:0] dd_r;
  logic [31:0] qx_r;
  logic [31:0] qv_r;
  logic [31:0] qv_d;

  assign d_c = Q_305 - x30_r;

  always_ff @(posedge clk) begin
    dd_r <= 32'(mul_rnd(34'(d_c), d_c, 30));
    qx_r <= 32'(mul_rnd(34'(Q_00121), x30_r, 30));
    qv_r <= 32'(mul_rnd(34'(dd_r), Q_0092, 30)) + Q_02253 - qx_r;
  end

  dfa_dly #(.W(32), .N(22)) u_qv_dly (.clk(clk), .d_i(qv_r), .q_o(qv_d));

  // Asymptotic branch: S(1/x^2) / x, with 1/x from a rounded division.
  logic [24:0] num_hi;
  logic [29:0] inv_q;
  logic [29:0] inv_d;
  logic [31:0] w_r;
  logic [33:0] s_h;
  logic [31:0] av_r;

  assign num_hi = 25'd1 << INPUT_FRACTION_BITS;

  dfa_div u_div (
    .clk     (clk),
    .dvs_i   (a_r),
    .num_hi_i(num_hi),
    .num_lo_i(30'(a_r >> 1)),
    .quo_o   (inv_q)
  );

  always_ff @(posedge clk) begin
    w_r <= 32'(mul_rnd(34'(inv_q), 32'(inv_q), 30));
  end

  dfa_horner u_asym_poly (.clk(clk), .mul_i(w_r), .coef_i(ASYM_COEF), .res_o(s_h));
  dfa_dly #(.W(30), .N(8)) u_inv_dly (.clk(clk), .d_i(inv_q), .q_o(inv_d));

  always_ff @(posedge clk) begin
    av_r <= 32'(mul_rnd(s_h, 32'(inv_d), 24));
  end

  // Branch select, scaling by 2/sqrt(pi), rounding, saturation and sign.
  logic [2:0]  ctl_d;
  br_t         br_d;
  logic [31:0] sel_c;
  logic [33:0] v_r;
  logic        neg_v_r;
  logic [26:0] mag_c;
  logic [22:0] sat_c;
  logic [23:0] res_nxt;
  logic [23:0] res_r;

  dfa_dly #(.W(3), .N(24)) u_ctl_dly (.clk(clk), .d_i({neg_r, br_r}), .q_o(ctl_d));

  assign br_d = br_t'(ctl_d[1:0]);

  always_comb begin
    case (br_d)
      BR_SER:  sel_c = sv_d;
      BR_QUAD: sel_c = qv_d;
      BR_ASYM: sel_c = av_r;
      default: sel_c = qv_d;
    endcase
  end

  always_ff @(posedge clk) begin
    v_r     <= 34'(mul_rnd(34'(sel_c), SCALE_K, 30));
    neg_v_r <= ctl_d[2];
  end

  assign mag_c   = 27'((35'(v_r) + 35'd128) >> 8);
  assign sat_c   = (mag_c > 27'(MAX_POS)) ? MAX_POS : mag_c[22:0];
  assign res_nxt = neg_v_r ? (24'd0 - {1'b0, sat_c}) : {1'b0, sat_c};

  always_ff @(posedge clk) begin
    res_r <= res_nxt;
  end

  assign busy             = busy_r;
  assign out_valid        = vld_r[LAT-1];
  assign out_result_value = res_r;

`ifndef SYNTH
  a_latency: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid == $past(start && !busy, 28))
    else $error("result strobe does not follow its transfer by the pipeline latency");

  a_sign: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_result_value == 24'sd0 ||
                   out_result_value[23] == $past(in_x_value[23], 28)))
    else $error("result sign differs from argument sign");

  a_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && $past(in_x_value, 28) == 24'sd0 |-> out_result_value == 24'sd0)
    else $error("zero argument gave a nonzero result");
`endif

endmodule

`default_nettype wire
